// ===== rtl/core/packed_morse_symbol_decoder_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the packed Morse symbol decoder
// Concurrent checks sampled on the rising clock edge, off while in reset.
// ---------------------------------------------------------------------------
`ifndef PACKED_MORSE_SYMBOL_DECODER_MACROS_SVH
`define PACKED_MORSE_SYMBOL_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packed_morse_symbol_decoder: check failed");

// The consequent must hold in the cycle after the antecedent.
`define PMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packed_morse_symbol_decoder: check failed");

`endif

// ===== rtl/core/pmsd_pkg.sv =====
// ---------------------------------------------------------------------------
// pmsd_pkg
// Symbol codes, result kinds and the Morse lookup table of the decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmsd_pkg;

  localparam logic [1:0] SYM_END   = 2'b00;
  localparam logic [1:0] SYM_DASH  = 2'b01;
  localparam logic [1:0] SYM_DOT   = 2'b10;
  localparam logic [1:0] SYM_SPACE = 2'b11;

  localparam logic [1:0] KIND_LETTER = 2'd0;
  localparam logic [1:0] KIND_SPACE  = 2'd1;
  localparam logic [1:0] KIND_BAD    = 2'd2;

  localparam logic [2:0] SYM_LIMIT  = 3'd6;
  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [7:0] NULL_CHAR  = 8'd0;

  // Returns {hit, character}. The code is right aligned, dash is 1, and the
  // first symbol is the most significant of the len used bits.
  function automatic logic [8:0] morse_lookup(input logic [2:0] len, input logic [5:0] bits);
    logic [8:0] res;
    res = 9'd0;
    unique case ({len, bits})
      {3'd1, 6'b000000}: res = {1'b1, 8'h45}; // E
      {3'd1, 6'b000001}: res = {1'b1, 8'h54}; // T
      {3'd2, 6'b000001}: res = {1'b1, 8'h41}; // A
      {3'd2, 6'b000000}: res = {1'b1, 8'h49}; // I
      {3'd2, 6'b000011}: res = {1'b1, 8'h4D}; // M
      {3'd2, 6'b000010}: res = {1'b1, 8'h4E}; // N
      {3'd3, 6'b000100}: res = {1'b1, 8'h44}; // D
      {3'd3, 6'b000110}: res = {1'b1, 8'h47}; // G
      {3'd3, 6'b000101}: res = {1'b1, 8'h4B}; // K
      {3'd3, 6'b000111}: res = {1'b1, 8'h4F}; // O
      {3'd3, 6'b000010}: res = {1'b1, 8'h52}; // R
      {3'd3, 6'b000000}: res = {1'b1, 8'h53}; // S
      {3'd3, 6'b000001}: res = {1'b1, 8'h55}; // U
      {3'd3, 6'b000011}: res = {1'b1, 8'h57}; // W
      {3'd4, 6'b001000}: res = {1'b1, 8'h42}; // B
      {3'd4, 6'b001010}: res = {1'b1, 8'h43}; // C
      {3'd4, 6'b000010}: res = {1'b1, 8'h46}; // F
      {3'd4, 6'b000000}: res = {1'b1, 8'h48}; // H
      {3'd4, 6'b000111}: res = {1'b1, 8'h4A}; // J
      {3'd4, 6'b000100}: res = {1'b1, 8'h4C}; // L
      {3'd4, 6'b000110}: res = {1'b1, 8'h50}; // P
      {3'd4, 6'b001101}: res = {1'b1, 8'h51}; // Q
      {3'd4, 6'b000001}: res = {1'b1, 8'h56}; // V
      {3'd4, 6'b001001}: res = {1'b1, 8'h58}; // X
      {3'd4, 6'b001011}: res = {1'b1, 8'h59}; // Y
      {3'd4, 6'b001100}: res = {1'b1, 8'h5A}; // Z
      {3'd4, 6'b000101}: res = {1'b1, 8'hC4}; // A umlaut
      {3'd4, 6'b001110}: res = {1'b1, 8'hD6}; // O umlaut
      {3'd4, 6'b000011}: res = {1'b1, 8'hDC}; // U umlaut
      {3'd4, 6'b001111}: res = {1'b1, 8'h8A}; // S caron
      {3'd5, 6'b011111}: res = {1'b1, 8'h30}; // 0
      {3'd5, 6'b001111}: res = {1'b1, 8'h31}; // 1
      {3'd5, 6'b000111}: res = {1'b1, 8'h32}; // 2
      {3'd5, 6'b000011}: res = {1'b1, 8'h33}; // 3
      {3'd5, 6'b000001}: res = {1'b1, 8'h34}; // 4
      {3'd5, 6'b000000}: res = {1'b1, 8'h35}; // 5
      {3'd5, 6'b010000}: res = {1'b1, 8'h36}; // 6
      {3'd5, 6'b011000}: res = {1'b1, 8'h37}; // 7
      {3'd5, 6'b011100}: res = {1'b1, 8'h38}; // 8
      {3'd5, 6'b011110}: res = {1'b1, 8'h39}; // 9
      {3'd5, 6'b000110}: res = {1'b1, 8'h21}; // !
      {3'd5, 6'b010001}: res = {1'b1, 8'h3D}; // =
      {3'd6, 6'b010101}: res = {1'b1, 8'h2E}; // .
      {3'd6, 6'b110011}: res = {1'b1, 8'h2C}; // ,
      {3'd6, 6'b001100}: res = {1'b1, 8'h3F}; // ?
      {3'd6, 6'b111000}: res = {1'b1, 8'h3A}; // :
      {3'd6, 6'b010010}: res = {1'b1, 8'h22}; // double quote
      {3'd6, 6'b011110}: res = {1'b1, 8'h27}; // apostrophe
      default:           res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/packed_morse_symbol_decoder.sv =====
// A byte is registered on its beat, then decoded into the result buffer once that is free.
// A byte yields 0 to 4 results; the single result port drains one beat per cycle
// while out_ready is high.
// A byte is taken while the previous byte's results still drain.
// Reset: synchronous active-low rst_n empties the buffers and clears the pending code.
// ---------------------------------------------------------------------------
// packed_morse_symbol_decoder
// Decodes bytes of four 2-bit Morse symbols into characters or bad-letter marks, one per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_morse_symbol_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_packed_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_character,
  output logic [1:0] out_result_kind,
  output logic       out_last_of_byte
);
  import pmsd_pkg::*;

  `include "packed_morse_symbol_decoder_macros.svh"

  logic       in_vld_r;
  logic [7:0] in_byte_r;

  logic [5:0] pend_sym_r, pend_sym_nxt;
  logic [2:0] pend_len_r, pend_len_nxt;
  logic       ovf_r, ovf_nxt;

  logic [7:0] res_char_r [4];
  logic [1:0] res_kind_r [4];
  logic [7:0] new_char   [4];
  logic [1:0] new_kind   [4];
  logic [2:0] new_cnt;
  logic [2:0] res_left_r;
  logic [1:0] res_rd_r;

  logic out_fire;
  logic proc_fire;

  assign out_valid        = (res_left_r != 3'd0);
  assign out_fire         = out_valid && out_ready;
  assign out_character    = res_char_r[res_rd_r];
  assign out_result_kind  = res_kind_r[res_rd_r];
  assign out_last_of_byte = (res_left_r == 3'd1);

  // The held byte is decoded once the buffer is empty or gives up its last beat.
  assign proc_fire = in_vld_r && ((res_left_r == 3'd0) || ((res_left_r == 3'd1) && out_ready));
  assign in_ready  = !in_vld_r || proc_fire;

  always_comb begin
    logic [5:0] sym_v;
    logic [2:0] len_v;
    logic       ovf_v;
    logic [2:0] cnt_v;
    logic [1:0] code;
    logic [8:0] look;
    sym_v = pend_sym_r;
    len_v = pend_len_r;
    ovf_v = ovf_r;
    cnt_v = 3'd0;
    code  = SYM_END;
    look  = 9'd0;
    for (int i = 0; i < 4; i++) begin
      new_char[i] = NULL_CHAR;
      new_kind[i] = KIND_BAD;
    end
    for (int s = 3; s >= 0; s--) begin
      code = in_byte_r[2*s +: 2];
      unique case (code) inside
        SYM_DASH, SYM_DOT: begin
          if (len_v < SYM_LIMIT) begin
            sym_v = {sym_v[4:0], (code == SYM_DASH)};
            len_v = len_v + 3'd1;
          end else begin
            ovf_v = 1'b1;
          end
        end
        SYM_SPACE: begin
          new_char[cnt_v[1:0]] = SPACE_CHAR;
          new_kind[cnt_v[1:0]] = KIND_SPACE;
          cnt_v = cnt_v + 3'd1;
        end
        SYM_END: begin
          // An end of letter with nothing pending produces no beat.
          if ((len_v != 3'd0) || ovf_v) begin
            look = morse_lookup(len_v, sym_v);
            if (!ovf_v && look[8]) begin
              new_char[cnt_v[1:0]] = look[7:0];
              new_kind[cnt_v[1:0]] = KIND_LETTER;
            end else begin
              new_char[cnt_v[1:0]] = NULL_CHAR;
              new_kind[cnt_v[1:0]] = KIND_BAD;
            end
            cnt_v = cnt_v + 3'd1;
            sym_v = 6'd0;
            len_v = 3'd0;
            ovf_v = 1'b0;
          end
        end
      endcase
    end
    pend_sym_nxt = sym_v;
    pend_len_nxt = len_v;
    ovf_nxt      = ovf_v;
    new_cnt      = cnt_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      pend_sym_r <= 6'd0;
      pend_len_r <= 3'd0;
      ovf_r      <= 1'b0;
      res_left_r <= 3'd0;
      res_rd_r   <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (proc_fire) begin
        in_vld_r <= 1'b0;
      end
      if (proc_fire) begin
        pend_sym_r <= pend_sym_nxt;
        pend_len_r <= pend_len_nxt;
        ovf_r      <= ovf_nxt;
        res_left_r <= new_cnt;
        res_rd_r   <= 2'd0;
      end else if (out_fire) begin
        res_left_r <= res_left_r - 3'd1;
        res_rd_r   <= res_rd_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_packed_byte;
    end
    if (proc_fire) begin
      for (int i = 0; i < 4; i++) begin
        res_char_r[i] <= new_char[i];
        res_kind_r[i] <= new_kind[i];
      end
    end
  end

  `PMSD_ASSERT_SAME(a_left_range, clk, rst_n, 1'b1, res_left_r <= 3'd4)
  `PMSD_ASSERT_SAME(a_len_range, clk, rst_n, 1'b1, pend_len_r <= SYM_LIMIT)
  `PMSD_ASSERT_SAME(a_ovf_full, clk, rst_n, ovf_r, pend_len_r == SYM_LIMIT)
  `PMSD_ASSERT_NEXT(a_drain_empty, clk, rst_n, out_fire && out_last_of_byte && !in_vld_r, !out_valid)

endmodule
